>>> hw/rtl/lfu_pkg.sv
package lfu_pkg;

  // request kinds
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_t;

  // what the update pass does to the target slot and the other ranks
  typedef enum logic [1:0] {
    MD_HIT,
    MD_EVICT,
    MD_INSERT
  } mode_t;

endpackage

>>> hw/rtl/lfu_cache_table.sv
// LFU key/value table, least recently touched entry breaks count ties.
// A miss or a disabled put takes a scan pass only; a hit or an insert takes a scan pass
// plus a read-modify-write pass over the slot RAM, one slot per cycle.
// Flow: a new word is taken only in idle, once the last result has moved to the output
// register; the next word is taken while that result waits.
// Reset: valid marks and occupancy clear at once, capacity returns to 16; RAM is not
// cleared, so no clearing pass is needed.
module lfu_cache_table #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [lfu_pkg::KEY_W-1:0]   in_key,
  input  logic [lfu_pkg::VAL_W-1:0]   in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [lfu_pkg::VAL_W-1:0]   out_read_value,
  output logic                        out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]   out_evicted_key,
  input  logic                        cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int AW   = $clog2(ENTRIES);
  localparam int RW   = AW;
  localparam int CTW  = $clog2(ENTRIES + 1);
  localparam int CMPW = (CTW > lfu_pkg::CAP_W) ? CTW : lfu_pkg::CAP_W;
  localparam int KW   = lfu_pkg::KEY_W;
  localparam int VW   = lfu_pkg::VAL_W;
  localparam int DW   = KW + VW + COUNT_BITS + RW;

  lfu_pkg::state_t state_r, state_nxt;

  // request and config
  logic                      req_func_r;
  logic [KW-1:0]             req_key_r;
  logic [VW-1:0]             req_val_r;
  logic [lfu_pkg::CAP_W-1:0] cap_r;

  // per-slot valid marks and fill count
  logic [ENTRIES-1:0] valid_r;
  logic [CTW-1:0]     occ_r;

  // pass sequencing: cnt_r issues reads, idx_r/rdv_r track data returning
  logic [CTW-1:0] cnt_r;
  logic [AW-1:0]  idx_r;
  logic           rdv_r;
  logic           issue, pass_end;

  // scan accumulators
  logic                  hit_f_r;
  logic [AW-1:0]         hit_idx_r;
  logic [RW-1:0]         hit_rank_r;
  logic [VW-1:0]         hit_val_r;
  logic                  vic_f_r;
  logic [AW-1:0]         vic_idx_r;
  logic [COUNT_BITS-1:0] vic_cnt_r;
  logic [RW-1:0]         vic_rank_r;
  logic [KW-1:0]         vic_key_r;
  logic                  free_f_r;
  logic [AW-1:0]         free_idx_r;

  // update plan
  lfu_pkg::mode_t mode_r;
  logic [AW-1:0]  tgt_r;
  logic [RW-1:0]  ref_rank_r;

  // pending result, output register
  logic          res_hit_r, res_ev_r;
  logic [VW-1:0] res_rd_r;
  logic [KW-1:0] res_evk_r;
  logic          out_valid_r;
  logic          out_load;

  // RAM
  logic          ram_we;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [KW-1:0]         rd_key;
  logic [VW-1:0]         rd_val;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [RW-1:0]         rd_rank;

  // decision at end of scan
  logic                  dec_upd;
  lfu_pkg::mode_t        dec_mode;
  logic [AW-1:0]         dec_tgt;
  logic [RW-1:0]         dec_rank;
  logic                  dec_hit, dec_ev;
  logic [VW-1:0]         dec_rd;
  logic [KW-1:0]         dec_evk;
  logic [CMPW-1:0]       cap_w, cap_eff, occ_w;

  // write-back word
  logic [KW-1:0]         wb_key;
  logic [VW-1:0]         wb_val;
  logic [COUNT_BITS-1:0] wb_cnt;
  logic [RW-1:0]         wb_rank;
  logic [RW-1:0]         inc_a, inc_b;

  assign rd_key  = ram_rdata[DW-1 -: KW];
  assign rd_val  = ram_rdata[DW-KW-1 -: VW];
  assign rd_cnt  = ram_rdata[RW +: COUNT_BITS];
  assign rd_rank = ram_rdata[RW-1:0];

  assign issue    = (state_r == lfu_pkg::ST_SCAN || state_r == lfu_pkg::ST_UPD) &&
                    (cnt_r < CTW'(ENTRIES));
  assign pass_end = (cnt_r == CTW'(ENTRIES)) && !rdv_r;

  assign in_ready  = (state_r == lfu_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == lfu_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // --- decide what the update pass will do ---
  always_comb begin
    cap_w    = CMPW'(cap_r);
    cap_eff  = (cap_w > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_w;
    occ_w    = CMPW'(occ_r);
    dec_upd  = 1'b0;
    dec_mode = lfu_pkg::MD_HIT;
    dec_tgt  = hit_idx_r;
    dec_rank = hit_rank_r;
    dec_hit  = 1'b0;
    dec_ev   = 1'b0;
    dec_rd   = '0;
    dec_evk  = '0;
    if (req_func_r == lfu_pkg::FUNC_GET) begin
      if (hit_f_r) begin
        dec_upd = 1'b1;
        dec_hit = 1'b1;
        dec_rd  = hit_val_r;
      end
    end else if (cap_eff != '0) begin
      if (hit_f_r) begin
        dec_upd = 1'b1;
        dec_hit = 1'b1;
      end else if (occ_w >= cap_eff) begin
        // full: reuse the victim's slot
        dec_upd  = 1'b1;
        dec_mode = lfu_pkg::MD_EVICT;
        dec_tgt  = vic_idx_r;
        dec_rank = vic_rank_r;
        dec_ev   = 1'b1;
        dec_evk  = vic_key_r;
      end else begin
        dec_upd  = 1'b1;
        dec_mode = lfu_pkg::MD_INSERT;
        dec_tgt  = free_idx_r;
        dec_rank = '0;
      end
    end
  end

  // --- write-back word for the update pass ---
  // ranks stay packed 0..occupancy-1; only their order matters, so an eviction
  // behaves as a touch of the reused slot
  always_comb begin
    inc_a = (mode_r == lfu_pkg::MD_INSERT) ? RW'(1) : '0;
    inc_b = (mode_r != lfu_pkg::MD_INSERT && rd_rank < ref_rank_r) ? RW'(1) : '0;
    wb_key  = rd_key;
    wb_val  = rd_val;
    wb_cnt  = rd_cnt;
    wb_rank = rd_rank;
    if (idx_r == tgt_r) begin
      wb_rank = '0;
      if (mode_r == lfu_pkg::MD_HIT) begin
        wb_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
        if (req_func_r == lfu_pkg::FUNC_PUT) begin
          wb_val = req_val_r;
        end
      end else begin
        wb_key = req_key_r;
        wb_val = req_val_r;
        wb_cnt = COUNT_BITS'(1);
      end
    end else if (valid_r[idx_r]) begin
      // newer entries age past the touched one; an insert ages everyone
      wb_rank = rd_rank + inc_a + inc_b;
    end
  end

  assign ram_we    = (state_r == lfu_pkg::ST_UPD) && rdv_r;
  assign ram_wdata = {wb_key, wb_val, wb_cnt, wb_rank};

  lfu_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // --- FSM ---
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_pkg::ST_IDLE: if (in_valid) state_nxt = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN: if (pass_end) begin
        state_nxt = dec_upd ? lfu_pkg::ST_UPD : lfu_pkg::ST_DONE;
      end
      lfu_pkg::ST_UPD:  if (pass_end) state_nxt = lfu_pkg::ST_DONE;
      lfu_pkg::ST_DONE: if (out_load) state_nxt = lfu_pkg::ST_IDLE;
      default:          state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --- control registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lfu_pkg::CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      rdv_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + CTW'(1);
      end else if (pass_end) begin
        cnt_r <= '0;
      end
      if (state_r == lfu_pkg::ST_SCAN && pass_end && dec_upd &&
          dec_mode == lfu_pkg::MD_INSERT) begin
        valid_r[dec_tgt] <= 1'b1;
        occ_r            <= occ_r + CTW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --- datapath registers ---
  always_ff @(posedge clk) begin
    idx_r <= cnt_r[AW-1:0];
    if (in_valid && in_ready) begin
      req_func_r <= in_func;
      req_key_r  <= in_key;
      req_val_r  <= in_value;
      hit_f_r    <= 1'b0;
      vic_f_r    <= 1'b0;
      free_f_r   <= 1'b0;
    end
    if (state_r == lfu_pkg::ST_SCAN && rdv_r) begin
      if (valid_r[idx_r] && rd_key == req_key_r && !hit_f_r) begin
        hit_f_r    <= 1'b1;
        hit_idx_r  <= idx_r;
        hit_rank_r <= rd_rank;
        hit_val_r  <= rd_val;
      end
      if (valid_r[idx_r] && (!vic_f_r || rd_cnt < vic_cnt_r ||
          (rd_cnt == vic_cnt_r && rd_rank > vic_rank_r))) begin
        vic_f_r    <= 1'b1;
        vic_idx_r  <= idx_r;
        vic_cnt_r  <= rd_cnt;
        vic_rank_r <= rd_rank;
        vic_key_r  <= rd_key;
      end
      if (!valid_r[idx_r] && !free_f_r) begin
        free_f_r   <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
    if (state_r == lfu_pkg::ST_SCAN && pass_end) begin
      mode_r     <= dec_mode;
      tgt_r      <= dec_tgt;
      ref_rank_r <= dec_rank;
      res_hit_r  <= dec_hit;
      res_rd_r   <= dec_rd;
      res_ev_r   <= dec_ev;
      res_evk_r  <= dec_evk;
    end
    if (out_load) begin
      out_hit         <= res_hit_r;
      out_read_value  <= res_rd_r;
      out_evicted     <= res_ev_r;
      out_evicted_key <= res_evk_r;
    end
  end

  // --- assertions ---
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CTW'(ENTRIES)) else $error("occupancy beyond table size");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r)) else $error("occupancy disagrees with valid marks");

  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfu_pkg::ST_SCAN && pass_end && dec_upd &&
     dec_mode == lfu_pkg::MD_INSERT) |-> free_f_r) else $error("insert without free slot");

  a_evict_vic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfu_pkg::ST_SCAN && pass_end && dec_upd &&
     dec_mode == lfu_pkg::MD_EVICT) |-> vic_f_r) else $error("evict without victim");

endmodule

>>> hw/rtl/lfu_ram.sv
// single write port, single read port, registered read data
module lfu_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 84
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SLOTS    = 16;
  localparam int CNT_W    = 16;
  localparam int DRAIN    = 60;   // above the hit/insert latency
  localparam int POOL_N   = 22;   // more live keys than slots, so evictions happen

  typedef struct {
    logic                      func;
    logic [lfu_pkg::KEY_W-1:0] key;
    logic [lfu_pkg::VAL_W-1:0] value;
  } request_t;

  typedef struct {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::KEY_W-1:0] evicted_key;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = lfu_pkg::FUNC_GET;
  logic [lfu_pkg::KEY_W-1:0] in_key = '0;
  logic [lfu_pkg::VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [lfu_pkg::VAL_W-1:0] out_read_value;
  logic out_evicted;
  logic [lfu_pkg::KEY_W-1:0] out_evicted_key;
  logic cfg_we = 1'b0;
  logic [lfu_pkg::CAP_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  lfu_cache_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the table, updated once per accepted request word.
  // ---------------------------------------------------------------------------
  logic [lfu_pkg::CAP_W-1:0] shadow_cap = lfu_pkg::CAP_RESET;
  logic                      tbl_valid [SLOTS];
  logic [lfu_pkg::KEY_W-1:0] tbl_key   [SLOTS];
  logic [lfu_pkg::VAL_W-1:0] tbl_val   [SLOTS];
  logic [CNT_W-1:0]          tbl_uses  [SLOTS];
  int unsigned               tbl_rank  [SLOTS];
  int                        tbl_fill = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_val[i]   = '0;
      tbl_uses[i]  = '0;
      tbl_rank[i]  = 0;
    end
  end

  // move slot s to the front of the recency order
  task automatic make_newest(input int s);
    int unsigned r;
    r = tbl_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (i != s && tbl_valid[i] && tbl_rank[i] < r) tbl_rank[i]++;
    tbl_rank[s] = 0;
  endtask

  task automatic bump_use(input int s);
    if (tbl_uses[s] != '1) tbl_uses[s]++;
    make_newest(s);
  endtask

  task automatic lfu_lookup(input request_t rq, output lookup_t res);
    int cap, s, v;
    cap = (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
    res = '{1'b0, '0, 1'b0, '0};
    s = -1;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_key[i] == rq.key) s = i;
    if (rq.func == lfu_pkg::FUNC_GET) begin
      if (s >= 0) begin
        res.hit = 1'b1;
        res.read_value = tbl_val[s];
        bump_use(s);
      end
    end else if (cap != 0) begin
      if (s >= 0) begin
        res.hit = 1'b1;
        tbl_val[s] = rq.value;
        bump_use(s);
      end else begin
        if (tbl_fill >= cap) begin
          // lowest use count, ties go to the stalest entry
          v = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i]) continue;
            if (v < 0 || tbl_uses[i] < tbl_uses[v] ||
                (tbl_uses[i] == tbl_uses[v] && tbl_rank[i] > tbl_rank[v])) v = i;
          end
          s = v;
          if (s >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = tbl_key[s];
            make_newest(s);
            tbl_valid[s] = 1'b0;
            tbl_fill--;
          end
        end
        if (s < 0)
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_valid[i]) s = i;
        if (s >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i]) tbl_rank[i]++;
          tbl_valid[s] = 1'b1;
          tbl_key[s]   = rq.key;
          tbl_val[s]   = rq.value;
          tbl_uses[s]  = CNT_W'(1);
          tbl_rank[s]  = 0;
          tbl_fill++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Queues and error bookkeeping
  // ---------------------------------------------------------------------------
  request_t pending_reqs[$];
  lookup_t  expected_lookups[$];
  int       err_count = 0;

  task automatic report(input string what);
    $display("[%0t] error: %s", $time, what);
    err_count++;
  endtask

  // random gap: half the time none, mostly short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Accept side: predict at the edge where a request word is taken, and track
  // the capacity register the same way.
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;

  always @(posedge clk) begin
    request_t rq;
    lookup_t  res;
    if (rst_n) begin
      if (cfg_we) shadow_cap = cfg_wdata;
      if (in_valid && in_ready) begin
        rq = '{in_func, in_key, in_value};
        lfu_lookup(rq, res);
        expected_lookups.push_back(res);
        in_taken = 1'b1;
      end
    end
  end

  // Driver: changes on the falling edge, holds the word until it is taken.
  int in_gap = 0;

  always @(negedge clk) begin
    request_t rq;
    if (rst_n && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        rq = pending_reqs.pop_front();
        in_func  <= rq.func;
        in_key   <= rq.key;
        in_value <= rq.value;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  int out_stall = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Monitor: compare each result word against the oldest prediction.
  always @(posedge clk) begin
    lookup_t exp_l;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        report("result word with no request outstanding");
      end else begin
        exp_l = expected_lookups.pop_front();
        if (out_hit !== exp_l.hit)
          report($sformatf("hit %b, want %b", out_hit, exp_l.hit));
        if (out_read_value !== exp_l.read_value)
          report($sformatf("read_value %h, want %h", out_read_value, exp_l.read_value));
        if (out_evicted !== exp_l.evicted)
          report($sformatf("evicted %b, want %b", out_evicted, exp_l.evicted));
        if (out_evicted_key !== exp_l.evicted_key)
          report($sformatf("evicted_key %h, want %h", out_evicted_key,
                           exp_l.evicted_key));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [lfu_pkg::KEY_W-1:0] key_pool[POOL_N];

  task automatic push_req(input logic f, input logic [lfu_pkg::KEY_W-1:0] k,
                          input logic [lfu_pkg::VAL_W-1:0] v);
    request_t rq;
    rq = '{f, k, v};
    pending_reqs.push_back(rq);
  endtask

  // block until the table has answered everything, then let it settle
  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || in_valid || expected_lookups.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int r;
    logic [lfu_pkg::KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85)      k = key_pool[$urandom_range(0, POOL_N - 1)];
      else if (r < 95) k = $urandom;
      else             k = ($urandom_range(0, 1) != 0) ? '1 : '0;
      push_req(($urandom_range(0, 99) < 55) ? lfu_pkg::FUNC_GET : lfu_pkg::FUNC_PUT,
               k, $urandom);
    end
  endtask

  initial begin
    // low-numbered capacities dominate; 31 checks clamping above the slot count
    logic [lfu_pkg::CAP_W-1:0] caps[8] = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd2, 5'd8, 5'd16,
                                           5'd17};
    for (int i = 0; i < POOL_N; i++) key_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: miss on empty, key extremes, put-update, get hit
    push_req(lfu_pkg::FUNC_GET, '0, '1);
    push_req(lfu_pkg::FUNC_PUT, '0, '1);
    push_req(lfu_pkg::FUNC_PUT, '1, '0);
    push_req(lfu_pkg::FUNC_GET, '0, '0);
    push_req(lfu_pkg::FUNC_GET, '1, '1);
    push_req(lfu_pkg::FUNC_PUT, '0, 32'h5a5a_a5a5);
    push_req(lfu_pkg::FUNC_GET, '0, '0);
    // fill the remaining slots
    for (int i = 2; i < SLOTS; i++) push_req(lfu_pkg::FUNC_PUT, key_pool[i], $urandom);
    // full table, new key: the pool keys tie at one use,
    // stalest of those goes first
    push_req(lfu_pkg::FUNC_PUT, key_pool[0], $urandom);
    push_req(lfu_pkg::FUNC_PUT, key_pool[1], $urandom);
    push_req(lfu_pkg::FUNC_GET, 32'h1234_5678, '0);

    // capacity dropped below occupancy: each new key evicts, table stays full
    set_capacity(5'd4);
    push_req(lfu_pkg::FUNC_PUT, key_pool[20], '1);
    push_req(lfu_pkg::FUNC_PUT, key_pool[21], '0);
    // disabled puts on a present key, get still hits
    set_capacity(5'd0);
    push_req(lfu_pkg::FUNC_PUT, '0, '1);
    push_req(lfu_pkg::FUNC_PUT, key_pool[20], 32'hdead_beef);
    push_req(lfu_pkg::FUNC_GET, key_pool[20], '0);

    foreach (caps[i]) begin
      set_capacity(caps[i]);
      random_phase(178);
    end

    wait_quiet();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
